@@ sv/slex_pkg.sv @@
// ----------------------------------------------------------------------------
// slex_pkg: shared types and constants for the source lexer
// token kinds, scanner modes, keyword table and character classes
// ----------------------------------------------------------------------------
package slex_pkg;

  // keyword prefix kept for an identifier, in bytes
  localparam int KwMaxLen   = 8;
  localparam int PrefixW    = KwMaxLen * 8;
  localparam int WlenW      = $clog2(KwMaxLen + 2);
  localparam int KwCount    = 18;

  localparam int KindW      = 6;
  localparam int OffW       = 32;
  localparam int LineW      = 16;

  // tokens one word can cause, and the group queue between front and back
  localparam int MaxTok     = 3;
  localparam int TokCntW    = 2;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [LineW-1:0] FirstLineReset = 16'd1;

  // input commands
  localparam logic CmdChar = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // token kinds
  localparam logic [KindW-1:0] KindLParen  = 6'd0;
  localparam logic [KindW-1:0] KindRParen  = 6'd1;
  localparam logic [KindW-1:0] KindLBrace  = 6'd2;
  localparam logic [KindW-1:0] KindRBrace  = 6'd3;
  localparam logic [KindW-1:0] KindComma   = 6'd4;
  localparam logic [KindW-1:0] KindDot     = 6'd5;
  localparam logic [KindW-1:0] KindMinus   = 6'd6;
  localparam logic [KindW-1:0] KindPlus    = 6'd7;
  localparam logic [KindW-1:0] KindSemi    = 6'd8;
  localparam logic [KindW-1:0] KindSlash   = 6'd9;
  localparam logic [KindW-1:0] KindStar    = 6'd10;
  localparam logic [KindW-1:0] KindColon   = 6'd11;
  localparam logic [KindW-1:0] KindBang    = 6'd12;
  localparam logic [KindW-1:0] KindEqual   = 6'd14;
  localparam logic [KindW-1:0] KindGreater = 6'd16;
  localparam logic [KindW-1:0] KindLess    = 6'd18;
  localparam logic [KindW-1:0] KindIdent   = 6'd20;
  localparam logic [KindW-1:0] KindNumber  = 6'd21;
  localparam logic [KindW-1:0] KindKwBase  = 6'd22;
  localparam logic [KindW-1:0] KindEof     = 6'd40;
  localparam logic [KindW-1:0] KindError   = 6'd41;

  // characters with a role of their own
  localparam logic [7:0] ChSlash   = 8'h2f;
  localparam logic [7:0] ChEqual   = 8'h3d;
  localparam logic [7:0] ChDot     = 8'h2e;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChUnder   = 8'h5f;
  localparam logic [7:0] ChBang    = 8'h21;
  localparam logic [7:0] ChGreater = 8'h3e;
  localparam logic [7:0] ChLess    = 8'h3c;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChTab     = 8'h09;

  typedef enum logic [2:0] {
    ModeIdle,
    ModePend,
    ModeComment,
    ModeIdent,
    ModeNumInt,
    ModeNumDot,
    ModeNumFrac
  } lex_mode_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [OffW-1:0]  start;
    logic [OffW-1:0]  stop;
  } token_t;

  // all tokens of one input word; they share the line number
  typedef struct packed {
    logic [TokCntW-1:0]        cnt;
    logic [LineW-1:0]          line;
    token_t [MaxTok-1:0]       tok;
  } group_t;

  // keyword text, right aligned, first byte most significant
  localparam logic [PrefixW-1:0] KwText [KwCount] = '{
    PrefixW'("and"),    PrefixW'("bool"),  PrefixW'("break"), PrefixW'("continue"),
    PrefixW'("else"),   PrefixW'("false"), PrefixW'("for"),   PrefixW'("fn"),
    PrefixW'("if"),     PrefixW'("num"),   PrefixW'("or"),    PrefixW'("print"),
    PrefixW'("return"), PrefixW'("super"), PrefixW'("this"),  PrefixW'("true"),
    PrefixW'("var"),    PrefixW'("while")
  };

  localparam logic [WlenW-1:0] KwLen [KwCount] = '{
    WlenW'(3), WlenW'(4), WlenW'(5), WlenW'(8), WlenW'(4), WlenW'(5),
    WlenW'(3), WlenW'(2), WlenW'(2), WlenW'(3), WlenW'(2), WlenW'(5),
    WlenW'(6), WlenW'(5), WlenW'(4), WlenW'(4), WlenW'(3), WlenW'(5)
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == ChUnder);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == ChBang) || (c == ChEqual) || (c == ChLess) || (c == ChGreater) ||
           (c == ChSlash);
  endfunction

  // one-character operator kind; its two-character form is the next code
  function automatic logic [KindW-1:0] op_kind(input logic [7:0] p);
    logic [KindW-1:0] k;
    unique case (p)
      ChBang:    k = KindBang;
      ChEqual:   k = KindEqual;
      ChGreater: k = KindGreater;
      default:   k = KindLess;
    endcase
    return k;
  endfunction

  // kind of a lone punctuator, valid flag in the msb
  function automatic logic [KindW:0] single_kind(input logic [7:0] c);
    logic [KindW:0] r;
    unique case (c)
      8'h28:   r = {1'b1, KindLParen};
      8'h29:   r = {1'b1, KindRParen};
      8'h7b:   r = {1'b1, KindLBrace};
      8'h7d:   r = {1'b1, KindRBrace};
      8'h2c:   r = {1'b1, KindComma};
      ChDot:   r = {1'b1, KindDot};
      8'h2d:   r = {1'b1, KindMinus};
      8'h2b:   r = {1'b1, KindPlus};
      8'h3b:   r = {1'b1, KindSemi};
      8'h2a:   r = {1'b1, KindStar};
      8'h3a:   r = {1'b1, KindColon};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [KindW-1:0] word_kind(input logic [PrefixW-1:0] prefix,
                                                 input logic [WlenW-1:0]   len);
    logic [KindW-1:0] k;
    k = KindIdent;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if ((len == KwLen[i]) && (prefix == KwText[i])) begin
        k = KindKwBase + KindW'(i);
      end
    end
    return k;
  endfunction

  function automatic token_t make_tok(input logic [KindW-1:0] kind,
                                      input logic [OffW-1:0]  start,
                                      input logic [OffW-1:0]  stop);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.stop  = stop;
    return t;
  endfunction

endpackage

@@ sv/slex_front.sv @@
// ----------------------------------------------------------------------------
// slex_front: scanner front end; takes one word per cycle while the queue
// has room, tracks the lexer state and builds token groups
// ----------------------------------------------------------------------------
module slex_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [7:0]                   ch_i,
  input  logic                         cfg_we_i,
  input  logic [slex_pkg::LineW-1:0]   cfg_wdata_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output slex_pkg::group_t             push_data_o
);

  slex_pkg::lex_mode_e                 mode_q, mode_d;
  logic [7:0]                          pend_q, pend_d;
  logic [slex_pkg::LineW-1:0]          line_q, line_d;
  logic [slex_pkg::LineW-1:0]          first_q, first_d;
  logic [slex_pkg::OffW-1:0]           pos_q, pos_d;
  logic [slex_pkg::OffW-1:0]           ts_q, ts_d;
  logic [slex_pkg::PrefixW-1:0]        pre_q, pre_d;
  logic [slex_pkg::WlenW-1:0]          wl_q, wl_d;

  logic                                take;
  logic                                do_flush;
  logic [slex_pkg::TokCntW-1:0]        n;
  logic [slex_pkg::KindW:0]            single;
  logic [slex_pkg::OffW-1:0]           pos_inc;
  slex_pkg::group_t                    grp;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign pos_inc    = pos_q + slex_pkg::OffW'(1);
  assign single     = slex_pkg::single_kind(ch_i);

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    line_d   = line_q;
    first_d  = first_q;
    pos_d    = pos_q;
    ts_d     = ts_q;
    pre_d    = pre_q;
    wl_d     = wl_q;
    grp      = '0;
    n        = '0;
    do_flush = 1'b0;

    if (take) begin
      if (command_i == slex_pkg::CmdEnd) begin
        do_flush = 1'b1;
      end else begin
        unique case (mode_q)
          slex_pkg::ModePend: begin
            if ((pend_q == slex_pkg::ChSlash) && (ch_i == slex_pkg::ChSlash)) begin
              mode_d = slex_pkg::ModeComment;
            end else if ((pend_q != slex_pkg::ChSlash) && (ch_i == slex_pkg::ChEqual)) begin
              grp.tok[n] = slex_pkg::make_tok(slex_pkg::op_kind(pend_q) + slex_pkg::KindW'(1),
                                              ts_q, pos_inc);
              n      = n + slex_pkg::TokCntW'(1);
              mode_d = slex_pkg::ModeIdle;
            end else begin
              do_flush = 1'b1;
            end
          end
          slex_pkg::ModeComment: begin
            do_flush = (ch_i == slex_pkg::ChNewline);
          end
          slex_pkg::ModeIdent: begin
            if (slex_pkg::is_alpha(ch_i) || slex_pkg::is_digit(ch_i)) begin
              if (wl_q < slex_pkg::WlenW'(slex_pkg::KwMaxLen)) begin
                pre_d = {pre_q[slex_pkg::PrefixW-9:0], ch_i};
                wl_d  = wl_q + slex_pkg::WlenW'(1);
              end else if (wl_q == slex_pkg::WlenW'(slex_pkg::KwMaxLen)) begin
                wl_d  = wl_q + slex_pkg::WlenW'(1);
              end
            end else begin
              do_flush = 1'b1;
            end
          end
          slex_pkg::ModeNumInt: begin
            if (ch_i == slex_pkg::ChDot) begin
              mode_d = slex_pkg::ModeNumDot;
            end else begin
              do_flush = !slex_pkg::is_digit(ch_i);
            end
          end
          slex_pkg::ModeNumDot: begin
            if (slex_pkg::is_digit(ch_i)) begin
              mode_d = slex_pkg::ModeNumFrac;
            end else begin
              do_flush = 1'b1;
            end
          end
          slex_pkg::ModeNumFrac: begin
            do_flush = !slex_pkg::is_digit(ch_i);
          end
          default: begin
            do_flush = 1'b1;
          end
        endcase
      end

      // close the token in progress
      if (do_flush) begin
        unique case (mode_q)
          slex_pkg::ModePend: begin
            grp.tok[n] = slex_pkg::make_tok((pend_q == slex_pkg::ChSlash) ?
                                            slex_pkg::KindSlash : slex_pkg::op_kind(pend_q),
                                            ts_q, pos_q);
            n = n + slex_pkg::TokCntW'(1);
          end
          slex_pkg::ModeIdent: begin
            grp.tok[n] = slex_pkg::make_tok(slex_pkg::word_kind(pre_q, wl_q), ts_q, pos_q);
            n = n + slex_pkg::TokCntW'(1);
          end
          slex_pkg::ModeNumInt, slex_pkg::ModeNumFrac: begin
            grp.tok[n] = slex_pkg::make_tok(slex_pkg::KindNumber, ts_q, pos_q);
            n = n + slex_pkg::TokCntW'(1);
          end
          slex_pkg::ModeNumDot: begin
            grp.tok[n] = slex_pkg::make_tok(slex_pkg::KindNumber, ts_q,
                                            pos_q - slex_pkg::OffW'(1));
            n = n + slex_pkg::TokCntW'(1);
            grp.tok[n] = slex_pkg::make_tok(slex_pkg::KindDot, pos_q - slex_pkg::OffW'(1),
                                            pos_q);
            n = n + slex_pkg::TokCntW'(1);
          end
          default: begin
          end
        endcase
        mode_d = slex_pkg::ModeIdle;
      end

      if (command_i == slex_pkg::CmdEnd) begin
        grp.tok[n] = slex_pkg::make_tok(slex_pkg::KindEof, pos_q, pos_q);
        n      = n + slex_pkg::TokCntW'(1);
        mode_d = slex_pkg::ModeIdle;
        pend_d = '0;
        pos_d  = '0;
        ts_d   = '0;
        line_d = first_q;
      end else begin
        pos_d = pos_inc;
        // start a new token with this byte
        if (do_flush) begin
          ts_d = pos_q;
          if (single[slex_pkg::KindW]) begin
            grp.tok[n] = slex_pkg::make_tok(single[slex_pkg::KindW-1:0], pos_q, pos_inc);
            n = n + slex_pkg::TokCntW'(1);
          end else if (slex_pkg::is_op(ch_i)) begin
            pend_d = ch_i;
            mode_d = slex_pkg::ModePend;
          end else if ((ch_i == slex_pkg::ChSpace) || (ch_i == slex_pkg::ChCr) ||
                       (ch_i == slex_pkg::ChTab)) begin
            mode_d = slex_pkg::ModeIdle;
          end else if (ch_i == slex_pkg::ChNewline) begin
            line_d = line_q + slex_pkg::LineW'(1);
          end else if (slex_pkg::is_digit(ch_i)) begin
            mode_d = slex_pkg::ModeNumInt;
          end else if (slex_pkg::is_alpha(ch_i)) begin
            pre_d  = slex_pkg::PrefixW'(ch_i);
            wl_d   = slex_pkg::WlenW'(1);
            mode_d = slex_pkg::ModeIdent;
          end else begin
            grp.tok[n] = slex_pkg::make_tok(slex_pkg::KindError, pos_q, pos_inc);
            n = n + slex_pkg::TokCntW'(1);
          end
        end
      end
    end

    // config write; the line counter follows only before a source's first byte
    if (cfg_we_i) begin
      first_d = cfg_wdata_i;
      if ((pos_q == '0) && (mode_q == slex_pkg::ModeIdle)) begin
        line_d = cfg_wdata_i;
      end
    end

    grp.cnt  = n;
    grp.line = line_q;
  end

  assign push_o      = take && (n != '0);
  assign push_data_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= slex_pkg::ModeIdle;
      pend_q  <= '0;
      line_q  <= slex_pkg::FirstLineReset;
      first_q <= slex_pkg::FirstLineReset;
      pos_q   <= '0;
      ts_q    <= '0;
      pre_q   <= '0;
      wl_q    <= '0;
    end else begin
      mode_q  <= mode_d;
      pend_q  <= pend_d;
      line_q  <= line_d;
      first_q <= first_d;
      pos_q   <= pos_d;
      ts_q    <= ts_d;
      pre_q   <= pre_d;
      wl_q    <= wl_d;
    end
  end

endmodule

@@ sv/slex_queue.sv @@
// ----------------------------------------------------------------------------
// slex_queue: token group queue
// small fifo that decouples the scanner from the token serializer
// ----------------------------------------------------------------------------
module slex_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  slex_pkg::group_t    push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output slex_pkg::group_t    head_o
);

  slex_pkg::group_t                 mem_q [slex_pkg::QueueDepth];
  logic [slex_pkg::QPtrW-1:0]       wr_q, wr_d;
  logic [slex_pkg::QPtrW-1:0]       rd_q, rd_d;
  logic [slex_pkg::QCntW-1:0]       cnt_q, cnt_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o  = (cnt_q == slex_pkg::QCntW'(slex_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + slex_pkg::QPtrW'(1) : wr_q;
    rd_d  = do_pop  ? rd_q + slex_pkg::QPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + slex_pkg::QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - slex_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ sv/slex_back.sv @@
// ----------------------------------------------------------------------------
// slex_back: token serializer
// hands out the tokens of the head group one word at a time
// ----------------------------------------------------------------------------
module slex_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slex_pkg::group_t             head_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [slex_pkg::KindW-1:0]   kind_o,
  output logic [slex_pkg::OffW-1:0]    start_offset_o,
  output logic [slex_pkg::OffW-1:0]    end_offset_o,
  output logic [slex_pkg::LineW-1:0]   line_number_o,
  output logic                         last_o
);

  logic [slex_pkg::TokCntW-1:0] idx_q, idx_d;
  logic                         fire;
  slex_pkg::token_t             tok;

  assign tok            = head_i.tok[idx_q];
  assign out_valid_o    = !empty_i;
  assign kind_o         = tok.kind;
  assign start_offset_o = tok.start;
  assign end_offset_o   = tok.stop;
  assign line_number_o  = head_i.line;
  assign last_o         = (idx_q == (head_i.cnt - slex_pkg::TokCntW'(1)));
  assign fire           = out_valid_o && out_ready_i;
  assign pop_o          = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? '0 : idx_q + slex_pkg::TokCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

@@ sv/source_lexer_top.sv @@
// ----------------------------------------------------------------------------
// source_lexer_top: streaming lexical analyzer
// source bytes in, tokens out as kind, byte offsets and line number
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_ready_o carry one word, command_i and
//   ch_i; command 0 is a source byte, command 1 ends the source, flushes the
//   token in progress and emits an eof token, then restarts offsets at zero
//   output channel: out_valid_o / out_ready_i carry one token per word;
//   last_o marks the final token caused by an input word (a word may cause
//   none, or up to three)
//   config: cfg_we_i writes cfg_wdata_i into first_line, and also into the
//   line counter while no byte has been taken since reset or the last end
// timing
//   a byte is taken every cycle as long as the group queue has room; the
//   scanner works on it in that cycle; its tokens leave the group queue
//   one token per cycle while out_ready_i is high; the four-entry queue
//   absorbs multi-token words and output stalls, and once it holds four
//   groups in_ready_o drops until the serializer retires one
// reset
//   asynchronous, active low; scanner idle, offsets zero, first_line and
//   line counter one, queue empty
// ----------------------------------------------------------------------------
module source_lexer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // source words
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic [7:0]                   ch_i,
  // first_line register
  input  logic                         cfg_we_i,
  input  logic [slex_pkg::LineW-1:0]   cfg_wdata_i,
  // token words
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [slex_pkg::KindW-1:0]   kind_o,
  output logic [slex_pkg::OffW-1:0]    start_offset_o,
  output logic [slex_pkg::OffW-1:0]    end_offset_o,
  output logic [slex_pkg::LineW-1:0]   line_number_o,
  output logic                         last_o
);

  // scanner to queue
  logic              push;
  slex_pkg::group_t  push_data;
  logic              q_full;

  // queue to serializer
  logic              pop;
  logic              q_empty;
  slex_pkg::group_t  head;

  // front: classifies each byte and builds the group of tokens it closes
  slex_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .ch_i        (ch_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // queue: holds whole groups so a three-token burst costs one entry
  slex_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // back: walks the head group, pops it after its last token is taken
  slex_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .start_offset_o (start_offset_o),
    .end_offset_o   (end_offset_o),
    .line_number_o  (line_number_o),
    .last_o         (last_o)
  );

endmodule
